### rtl/bsa_pkg.sv
package bsa_pkg;

    localparam logic [2:0] REQ_SET       = 3'd0;
    localparam logic [2:0] REQ_CLEAR     = 3'd1;
    localparam logic [2:0] REQ_TEST      = 3'd2;
    localparam logic [2:0] REQ_CLEAR_ALL = 3'd3;
    localparam logic [2:0] REQ_SET_ALL   = 3'd4;
    localparam logic [2:0] REQ_FIND      = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [7:0]  BYTE_ONES  = 8'hff;
    localparam logic [7:0]  BYTE_ZERO  = 8'h00;
    localparam logic [7:0]  BIT_ONE    = 8'h01;
    localparam logic [10:0] SIZE_RESET = 11'd1024;
    localparam int          CHUNK_W    = 32;

    typedef struct packed {
        logic       capture;
        logic       cnt_inc;
        logic       rd_bit;
        logic       bit_update;
        logic       wr_fill;
        logic       fill_ones;
        logic       rd_find;
        logic       find_update;
        logic       res_load;
        logic [1:0] res_status;
    } t_bsa_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       beyond_cap;
        logic       in_range;
        logic       none_in_use;
        logic       sweep_last;
        logic       init_last;
        logic       chunk_hit;
        logic       chunk_last;
    } t_bsa_stat;

endpackage

### rtl/bsa_ctrl.sv
module bsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    input  bsa_pkg::t_bsa_stat  i_stat,
    output bsa_pkg::t_bsa_cmd   o_cmd
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_BIT,
        S_SWEEP,
        S_SCAN,
        S_FIND,
        S_DONE
    } t_state;

    t_state   r_state;
    t_state   n_state;
    logic     r_req_ready;
    logic     r_rsp_valid;
    t_bsa_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_INIT: begin
                w_cmd.wr_fill = 1'b1;
                w_cmd.cnt_inc = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req)
                    REQ_SET, REQ_CLEAR, REQ_TEST: begin
                        if (i_stat.req == REQ_SET && i_stat.beyond_cap) begin
                            w_cmd.res_load   = 1'b1;
                            w_cmd.res_status = ST_FULL;
                            n_state          = S_DONE;
                        end else if (!i_stat.in_range) begin
                            w_cmd.res_load   = 1'b1;
                            w_cmd.res_status = ST_BAD_INDEX;
                            n_state          = S_DONE;
                        end else begin
                            w_cmd.rd_bit = 1'b1;
                            n_state      = S_BIT;
                        end
                    end
                    REQ_CLEAR_ALL, REQ_SET_ALL: begin
                        n_state = i_stat.none_in_use ? S_DONE : S_SWEEP;
                    end
                    REQ_FIND: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        w_cmd.res_load   = 1'b1;
                        w_cmd.res_status = ST_BAD_INDEX;
                        n_state          = S_DONE;
                    end
                endcase
            end
            S_BIT: begin
                w_cmd.bit_update = 1'b1;
                n_state          = S_DONE;
            end
            S_SWEEP: begin
                w_cmd.wr_fill   = 1'b1;
                w_cmd.fill_ones = (i_stat.req == REQ_SET_ALL);
                w_cmd.cnt_inc   = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.chunk_hit) begin
                    w_cmd.rd_find = 1'b1;
                    n_state       = S_FIND;
                end else if (i_stat.chunk_last) begin
                    w_cmd.res_load   = 1'b1;
                    w_cmd.res_status = ST_FULL;
                    n_state          = S_DONE;
                end else begin
                    w_cmd.cnt_inc = 1'b1;
                end
            end
            S_FIND: begin
                w_cmd.find_update = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_req_ready <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req_ready <= (n_state == S_IDLE);
            r_rsp_valid <= (n_state == S_DONE);
        end
    end

    assign o_cmd       = w_cmd;
    assign o_req_ready = r_req_ready;
    assign o_rsp_valid = r_rsp_valid;

    a_scan_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !i_stat.chunk_hit && !i_stat.chunk_last) |=> (r_state == S_SCAN))
        else $error("scan left early without a hit");

    a_bit_after_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |-> ($past(r_state) == S_DECODE))
        else $error("bit update without a preceding read");

endmodule

### rtl/bsa_datapath.sv
module bsa_datapath #(
    parameter int NUM_BYTES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_wdata,
    input  logic [2:0]         i_req_type,
    input  logic [9:0]         i_bit_index,
    input  bsa_pkg::t_bsa_cmd  i_cmd,
    output bsa_pkg::t_bsa_stat o_stat,
    output logic [1:0]         o_status,
    output logic               o_bit_was_set,
    output logic [9:0]         o_found_position
);
    import bsa_pkg::*;

    localparam int AW   = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int CW   = $clog2(NUM_BYTES + 1);
    localparam int NW   = (CW > 9) ? CW : 9;
    localparam int NCH  = (NUM_BYTES + CHUNK_W - 1) / CHUNK_W;
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int EW   = (NW > CHW + 5) ? NW : CHW + 5;
    localparam int PADW = NCH * CHUNK_W;

    logic [7:0]         r_mem [0:NUM_BYTES-1];
    logic [NUM_BYTES-1:0] r_full;
    logic [7:0]         r_rdata;
    logic [2:0]         r_req;
    logic [9:0]         r_bit;
    logic [10:0]        r_size;
    logic [AW-1:0]      r_cnt;
    logic [AW-1:0]      r_faddr;
    logic [1:0]         r_status;
    logic               r_was_set;
    logic [9:0]         r_pos;

    logic [11:0]        w_sum;
    logic [EW-1:0]      w_raw;
    logic [EW-1:0]      w_nbytes;
    logic [EW+2:0]      w_bit_ext;
    logic [EW+2:0]      w_limit;
    logic [AW-1:0]      w_bit_addr;
    logic [7:0]         w_mask;
    logic [PADW-1:0]    w_pad;
    logic [CHW-1:0]     w_chunk;
    logic [CHUNK_W-1:0] w_slice;
    logic [CHUNK_W-1:0] w_free;
    logic [4:0]         w_enc;
    logic [EW-1:0]      w_fidx;
    logic [2:0]         w_fbit;
    logic [EW+2:0]      w_fpos;
    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic [7:0]         w_wd;
    logic [AW-1:0]      w_ra;

    assign w_sum      = {1'b0, r_size} + 12'd7;
    assign w_raw      = EW'(w_sum[11:3]);
    assign w_nbytes   = (w_raw > EW'(NUM_BYTES)) ? EW'(NUM_BYTES) : w_raw;
    assign w_bit_ext  = (EW + 3)'(r_bit);
    assign w_limit    = {w_nbytes, 3'b000};
    assign w_bit_addr = AW'(EW'(r_bit[9:3]));
    assign w_mask     = BIT_ONE << r_bit[2:0];

    for (genvar g = 0; g < PADW; g++) begin : g_pad
        if (g < NUM_BYTES) begin : g_used
            assign w_pad[g] = r_full[g];
        end else begin : g_spare
            assign w_pad[g] = 1'b1;
        end
    end

    assign w_chunk = r_cnt[CHW-1:0];
    assign w_slice = w_pad[{w_chunk, 5'd0} +: CHUNK_W];

    always_comb begin
        logic [EW-1:0] v_idx;
        v_idx  = '0;
        w_free = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            v_idx     = EW'({w_chunk, 5'(j)});
            w_free[j] = !w_slice[j] && (v_idx < w_nbytes);
        end
    end

    always_comb begin
        w_enc = '0;
        for (int j = CHUNK_W - 1; j >= 0; j--) begin
            if (w_free[j]) begin
                w_enc = 5'(j);
            end
        end
    end

    assign w_fidx = EW'({w_chunk, w_enc});

    always_comb begin
        w_fbit = 3'd7;
        for (int k = 6; k >= 0; k--) begin
            if (!r_rdata[k]) begin
                w_fbit = 3'(k);
            end
        end
    end

    assign w_fpos = (EW + 3)'({r_faddr, w_fbit});

    always_comb begin
        w_we = 1'b0;
        w_wa = r_cnt;
        w_wd = BYTE_ZERO;
        if (i_cmd.wr_fill) begin
            w_we = 1'b1;
            w_wd = i_cmd.fill_ones ? BYTE_ONES : BYTE_ZERO;
        end else if (i_cmd.bit_update && (r_req inside {REQ_SET, REQ_CLEAR})) begin
            w_we = 1'b1;
            w_wa = w_bit_addr;
            w_wd = (r_req == REQ_SET) ? (r_rdata | w_mask) : (r_rdata & ~w_mask);
        end else if (i_cmd.find_update) begin
            w_we = 1'b1;
            w_wa = r_faddr;
            w_wd = r_rdata | (BIT_ONE << w_fbit);
        end
    end

    assign w_ra = i_cmd.rd_find ? w_fidx[AW-1:0] : w_bit_addr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_bit || i_cmd.rd_find) begin
            r_rdata <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            r_size <= SIZE_RESET;
            r_cnt  <= '0;
        end else begin
            if (w_we) begin
                r_full[w_wa] <= (w_wd == BYTE_ONES);
            end
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (i_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req     <= i_req_type;
            r_bit     <= i_bit_index;
            r_status  <= ST_OK;
            r_was_set <= 1'b0;
            r_pos     <= '0;
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
        end
        if (i_cmd.bit_update && r_req == REQ_TEST) begin
            r_was_set <= |(r_rdata & w_mask);
        end
        if (i_cmd.rd_find) begin
            r_faddr <= w_fidx[AW-1:0];
        end
        if (i_cmd.find_update) begin
            r_pos <= w_fpos[9:0];
        end
    end

    assign o_stat.req         = r_req;
    assign o_stat.beyond_cap  = (w_bit_ext >= (EW + 3)'(NUM_BYTES * 8));
    assign o_stat.in_range    = (w_bit_ext < w_limit);
    assign o_stat.none_in_use = (w_nbytes == '0);
    assign o_stat.sweep_last  = (EW'(r_cnt) == w_nbytes - 1'b1);
    assign o_stat.init_last   = (r_cnt == AW'(NUM_BYTES - 1));
    assign o_stat.chunk_hit   = |w_free;
    assign o_stat.chunk_last  = (w_chunk == CHW'(NCH - 1));

    assign o_status         = r_status;
    assign o_bit_was_set    = r_was_set;
    assign o_found_position = r_pos;

    a_found_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.find_update |-> (r_rdata != BYTE_ONES))
        else $error("allocation chose a byte with no clear bit");

    a_find_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.find_update |-> $past(i_cmd.rd_find))
        else $error("allocation write without a byte read");

endmodule

### rtl/bitmap_slot_allocator.sv
// Channel   Direction  Handshake                     Payload
// request   in         i_req_valid / o_req_ready     i_req_type, i_bit_index
// response  out        o_rsp_valid / i_rsp_ready     o_status, o_bit_was_set, o_found_position
// config    in         i_cfg_we                      i_cfg_wdata
//
// Set, clear and test read the addressed byte, then set or clear its bit or record it (test).
// A refused index or an unknown request goes straight to the response.
// Find and set searches 32-byte groups in order and marks the first clear bit, or reports full.
// Clear all and set all write each byte in use, one memory write a cycle.
// After reset a clearing pass zeroes the map before the first request.
// One request is in flight at a time; a stalled response holds the block until it is taken.
module bitmap_slot_allocator #(
    parameter int NUM_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [2:0]  i_req_type,
    input  logic [9:0]  i_bit_index,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [1:0]  o_status,
    output logic        o_bit_was_set,
    output logic [9:0]  o_found_position,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);
    import bsa_pkg::*;

    t_bsa_cmd  w_cmd;
    t_bsa_stat w_stat;

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bsa_datapath #(
        .NUM_BYTES (NUM_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req_type),
        .i_bit_index      (i_bit_index),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_status         (o_status),
        .o_bit_was_set    (o_bit_was_set),
        .o_found_position (o_found_position)
    );

endmodule
